// ===== rtl/core/mfek_pkg.sv =====
// shared types and constants for the edmonds-karp max flow core
// no dependencies
`default_nettype none
package mfek_pkg;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_ADD     = 2'd1;
  localparam logic [1:0] CMD_RUN     = 2'd2;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_SOURCE     = 2'd1;
  localparam logic [1:0] REG_SINK       = 2'd2;

  localparam logic [6:0] NODE_COUNT_RST = 7'd64;
  localparam logic [5:0] SOURCE_RST     = 6'd0;
  localparam logic [5:0] SINK_RST       = 6'd63;

  localparam int CFG_DATA_W = 7;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  node_a;
    logic [5:0]  node_b;
    logic [15:0] capacity;
  } item_t;

  typedef struct packed {
    logic [31:0] flow_total;
    logic        flow_saturated;
  } result_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR,
    OP_ADD_RD,
    OP_ADD_WR1,
    OP_ADD_WR2,
    OP_BFS_INIT,
    OP_DEQ,
    OP_SCAN_START,
    OP_SCAN,
    OP_W1_INIT,
    OP_W2_INIT,
    OP_PAR,
    OP_FWD,
    OP_W1_CMP,
    OP_W2_SUB,
    OP_W2_ADD,
    OP_ACC
  } dp_op_t;

  typedef struct packed {
    logic clr_last;
    logic edge_ok;
    logic self_loop;
    logic run_ok;
    logic q_empty;
    logic found;
    logic scan_done;
    logic walk_end;
    logic bott_zero;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/mfek_ram.sv =====
// generic one-write one-read ram with registered read data
// no dependencies
`default_nettype none
module mfek_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/mfek_dp.sv =====
// datapath: residual matrix, bfs queue, parent table, walk and flow registers
// depends on mfek_pkg and mfek_ram
`default_nettype none
module mfek_dp #(
  parameter int MAX_NODES = 64,
  parameter int CAP_WIDTH = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire mfek_pkg::dp_op_t                  op,
  input  wire mfek_pkg::item_t                   item,
  input  wire logic                              cfg_write,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [mfek_pkg::CFG_DATA_W-1:0]   cfg_data,
  output mfek_pkg::dp_status_t                   status,
  output mfek_pkg::result_t                      result
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = NW + 1;
  localparam int VN  = 1 << NW;
  localparam int RA  = 2 * NW;
  localparam int AW  = (CAP_WIDTH > 16) ? CAP_WIDTH : 16;
  localparam int FW  = ((CAP_WIDTH > 32) ? CAP_WIDTH : 32) + 1;
  localparam logic [AW:0]   CAP_LIM  = (AW+1)'({CAP_WIDTH{1'b1}});
  localparam logic [FW-1:0] FLOW_LIM = FW'(32'hFFFF_FFFF);
  localparam logic [CW-1:0] MAX_CW   = CW'(MAX_NODES);

  function automatic logic [CAP_WIDTH-1:0] sat_add(input logic [CAP_WIDTH-1:0] x,
                                                   input logic [AW-1:0] y);
    logic [AW:0] s;
    s = (AW+1)'(x) + (AW+1)'(y);
    return (s > CAP_LIM) ? {CAP_WIDTH{1'b1}} : s[CAP_WIDTH-1:0];
  endfunction

  // configuration
  logic [6:0] node_count;
  logic [5:0] source_node;
  logic [5:0] sink_node;

  // latched beat
  logic [5:0]  a_r;
  logic [5:0]  b_r;
  logic [15:0] cap_r;

  logic [RA-1:0]        clr_addr;
  logic [VN-1:0]        visited;
  logic [CW-1:0]        head;
  logic [CW-1:0]        tail;
  logic [NW-1:0]        u;
  logic [CW-1:0]        v;
  logic [NW-1:0]        v_d;
  logic                 chk;
  logic [NW-1:0]        i_r;
  logic [NW-1:0]        p_r;
  logic [CW-1:0]        steps;
  logic [CAP_WIDTH-1:0] bott;
  logic [31:0]          flow;
  logic                 sat;

  logic                 res_we;
  logic [RA-1:0]        res_waddr;
  logic [CAP_WIDTH-1:0] res_wdata;
  logic [RA-1:0]        res_raddr;
  logic [CAP_WIDTH-1:0] res_rdata;
  logic                 par_we;
  logic [NW-1:0]        par_waddr;
  logic [NW-1:0]        par_wdata;
  logic [NW-1:0]        par_raddr;
  logic [NW-1:0]        par_rdata;
  logic                 q_we;
  logic [NW-1:0]        q_waddr;
  logic [NW-1:0]        q_wdata;
  logic [NW-1:0]        q_raddr;
  logic [NW-1:0]        q_rdata;

  logic [CW-1:0] n_eff;
  logic [NW-1:0] a_i;
  logic [NW-1:0] b_i;
  logic [NW-1:0] src_i;
  logic [NW-1:0] snk_i;
  logic          v_in;
  logic          hit;
  logic          is_snk;
  logic          q_room;
  logic [FW-1:0] fsum;

  assign n_eff  = (32'(node_count) > 32'(MAX_NODES)) ? MAX_CW : CW'(node_count);
  assign a_i    = NW'(a_r);
  assign b_i    = NW'(b_r);
  assign src_i  = NW'(source_node);
  assign snk_i  = NW'(sink_node);
  assign v_in   = v < n_eff;
  assign hit    = chk && !visited[v_d] && (res_rdata != '0);
  assign is_snk = v_d == snk_i;
  assign q_room = tail < MAX_CW;
  assign fsum   = FW'(flow) + FW'(bott);

  assign status.clr_last  = &clr_addr;
  assign status.edge_ok   = (32'(a_r) < 32'(MAX_NODES)) && (32'(b_r) < 32'(MAX_NODES));
  assign status.self_loop = a_r == b_r;
  assign status.run_ok    = (32'(source_node) < 32'(n_eff)) &&
                            (32'(sink_node) < 32'(n_eff)) && (source_node != sink_node);
  assign status.q_empty   = head == tail;
  assign status.found     = hit && is_snk;
  assign status.scan_done = !chk && !v_in;
  assign status.walk_end  = (i_r == src_i) || (steps >= n_eff);
  assign status.bott_zero = bott == '0;

  assign result.flow_total     = flow;
  assign result.flow_saturated = sat;

  always_comb begin
    res_we    = 1'b0;
    res_waddr = '0;
    res_wdata = '0;
    res_raddr = '0;
    par_we    = 1'b0;
    par_waddr = '0;
    par_wdata = '0;
    par_raddr = '0;
    q_we      = 1'b0;
    q_waddr   = '0;
    q_wdata   = '0;
    q_raddr   = '0;
    case (op)
      mfek_pkg::OP_CLR: begin
        res_we    = 1'b1;
        res_waddr = clr_addr;
      end
      mfek_pkg::OP_ADD_RD: begin
        res_raddr = {a_i, b_i};
      end
      mfek_pkg::OP_ADD_WR1: begin
        res_we    = 1'b1;
        res_waddr = {a_i, b_i};
        res_wdata = sat_add(res_rdata, AW'(cap_r));
        res_raddr = {b_i, a_i};
      end
      mfek_pkg::OP_ADD_WR2: begin
        res_we    = 1'b1;
        res_waddr = {b_i, a_i};
        res_wdata = sat_add(res_rdata, AW'(cap_r));
      end
      mfek_pkg::OP_BFS_INIT: begin
        q_we      = 1'b1;
        q_wdata   = src_i;
        par_we    = 1'b1;
        par_waddr = src_i;
        par_wdata = src_i;
      end
      mfek_pkg::OP_DEQ: begin
        q_raddr = head[NW-1:0];
      end
      mfek_pkg::OP_SCAN: begin
        res_raddr = {u, v[NW-1:0]};
        if (hit) begin
          par_we    = 1'b1;
          par_waddr = v_d;
          par_wdata = u;
          if (!is_snk && q_room) begin
            q_we    = 1'b1;
            q_waddr = tail[NW-1:0];
            q_wdata = v_d;
          end
        end
      end
      mfek_pkg::OP_PAR: begin
        par_raddr = i_r;
      end
      mfek_pkg::OP_FWD: begin
        res_raddr = {par_rdata, i_r};
      end
      mfek_pkg::OP_W2_SUB: begin
        res_we    = 1'b1;
        res_waddr = {p_r, i_r};
        res_wdata = res_rdata - bott;
        res_raddr = {i_r, p_r};
      end
      mfek_pkg::OP_W2_ADD: begin
        res_we    = 1'b1;
        res_waddr = {i_r, p_r};
        res_wdata = sat_add(res_rdata, AW'(bott));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= mfek_pkg::NODE_COUNT_RST;
      source_node <= mfek_pkg::SOURCE_RST;
      sink_node   <= mfek_pkg::SINK_RST;
      clr_addr    <= '0;
      visited     <= '0;
      flow        <= '0;
      sat         <= 1'b0;
      bott        <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          mfek_pkg::REG_NODE_COUNT: node_count  <= cfg_data[6:0];
          mfek_pkg::REG_SOURCE:     source_node <= cfg_data[5:0];
          mfek_pkg::REG_SINK:       sink_node   <= cfg_data[5:0];
          default: ;
        endcase
      end
      case (op)
        mfek_pkg::OP_LOAD: begin
          a_r      <= item.node_a;
          b_r      <= item.node_b;
          cap_r    <= item.capacity;
          clr_addr <= '0;
          flow     <= '0;
          sat      <= 1'b0;
        end
        mfek_pkg::OP_CLR: clr_addr <= clr_addr + 1'b1;
        mfek_pkg::OP_BFS_INIT: begin
          // only the source starts out visited
          visited <= {{(VN-1){1'b0}}, 1'b1} << src_i;
          head    <= '0;
          tail    <= CW'(1);
        end
        mfek_pkg::OP_DEQ: head <= head + 1'b1;
        mfek_pkg::OP_SCAN_START: begin
          u   <= q_rdata;
          v   <= '0;
          chk <= 1'b0;
        end
        mfek_pkg::OP_SCAN: begin
          // read issued for v, checked in the next cycle as v_d
          chk <= v_in;
          v_d <= v[NW-1:0];
          if (v_in) begin
            v <= v + 1'b1;
          end
          if (hit && !is_snk) begin
            visited[v_d] <= 1'b1;
            if (q_room) begin
              tail <= tail + 1'b1;
            end
          end
        end
        mfek_pkg::OP_W1_INIT: begin
          i_r   <= snk_i;
          steps <= '0;
          bott  <= '1;
        end
        mfek_pkg::OP_W2_INIT: begin
          i_r   <= snk_i;
          steps <= '0;
        end
        mfek_pkg::OP_FWD: p_r <= par_rdata;
        mfek_pkg::OP_W1_CMP: begin
          if (res_rdata < bott) begin
            bott <= res_rdata;
          end
          i_r   <= p_r;
          steps <= steps + 1'b1;
        end
        mfek_pkg::OP_W2_ADD: begin
          i_r   <= p_r;
          steps <= steps + 1'b1;
        end
        mfek_pkg::OP_ACC: begin
          if (bott != '0) begin
            if (fsum >= FLOW_LIM) begin
              flow <= '1;
              sat  <= 1'b1;
            end else begin
              flow <= fsum[31:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  mfek_ram #(.WIDTH(CAP_WIDTH), .DEPTH(1 << RA)) u_res (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .raddr (res_raddr),
    .rdata (res_rdata)
  );

  mfek_ram #(.WIDTH(NW), .DEPTH(VN)) u_par (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  mfek_ram #(.WIDTH(NW), .DEPTH(VN)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

endmodule
`default_nettype wire

// ===== rtl/core/mfek_ctrl.sv =====
// controller: sequences clear, edge load, bfs, path walks and result beat
// depends on mfek_pkg
`default_nettype none
module mfek_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [1:0]           command,
  input  wire mfek_pkg::dp_status_t status,
  output mfek_pkg::dp_op_t          op,
  output logic                      busy,
  output logic                      done
);

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR1,
    S_ADD_WR2,
    S_RUN_CHK,
    S_BFS_INIT,
    S_DEQ,
    S_SCAN_START,
    S_SCAN,
    S_W1_INIT,
    S_W1_PAR,
    S_W1_FWD,
    S_W1_CMP,
    S_W2_INIT,
    S_W2_PAR,
    S_W2_FWD,
    S_W2_SUB,
    S_W2_ADD,
    S_ACC
  } state_t;

  state_t state;
  state_t state_next;
  logic   fin;

  assign busy = state != S_IDLE;

  always_comb begin
    op         = mfek_pkg::OP_NONE;
    state_next = state;
    fin        = 1'b0;
    unique case (state)
      S_CLR: begin
        op = mfek_pkg::OP_CLR;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op = mfek_pkg::OP_LOAD;
          unique case (command)
            mfek_pkg::CMD_CLEAR: state_next = S_CLR;
            mfek_pkg::CMD_ADD:   state_next = S_ADD_RD;
            mfek_pkg::CMD_RUN:   state_next = S_RUN_CHK;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_RD: begin
        if (status.edge_ok) begin
          op         = mfek_pkg::OP_ADD_RD;
          state_next = S_ADD_WR1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ADD_WR1: begin
        op         = mfek_pkg::OP_ADD_WR1;
        state_next = status.self_loop ? S_IDLE : S_ADD_WR2;
      end
      S_ADD_WR2: begin
        op         = mfek_pkg::OP_ADD_WR2;
        state_next = S_IDLE;
      end
      S_RUN_CHK: begin
        if (status.run_ok) begin
          state_next = S_BFS_INIT;
        end else begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_BFS_INIT: begin
        op         = mfek_pkg::OP_BFS_INIT;
        state_next = S_DEQ;
      end
      S_DEQ: begin
        // empty queue means no augmenting path is left
        if (status.q_empty) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          op         = mfek_pkg::OP_DEQ;
          state_next = S_SCAN_START;
        end
      end
      S_SCAN_START: begin
        op         = mfek_pkg::OP_SCAN_START;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        op = mfek_pkg::OP_SCAN;
        if (status.found) begin
          state_next = S_W1_INIT;
        end else if (status.scan_done) begin
          state_next = S_DEQ;
        end
      end
      S_W1_INIT: begin
        op         = mfek_pkg::OP_W1_INIT;
        state_next = S_W1_PAR;
      end
      S_W1_PAR: begin
        if (status.walk_end) begin
          state_next = S_W2_INIT;
        end else begin
          op         = mfek_pkg::OP_PAR;
          state_next = S_W1_FWD;
        end
      end
      S_W1_FWD: begin
        op         = mfek_pkg::OP_FWD;
        state_next = S_W1_CMP;
      end
      S_W1_CMP: begin
        op         = mfek_pkg::OP_W1_CMP;
        state_next = S_W1_PAR;
      end
      S_W2_INIT: begin
        op         = mfek_pkg::OP_W2_INIT;
        state_next = S_W2_PAR;
      end
      S_W2_PAR: begin
        if (status.walk_end) begin
          state_next = S_ACC;
        end else begin
          op         = mfek_pkg::OP_PAR;
          state_next = S_W2_FWD;
        end
      end
      S_W2_FWD: begin
        op         = mfek_pkg::OP_FWD;
        state_next = S_W2_SUB;
      end
      S_W2_SUB: begin
        op         = mfek_pkg::OP_W2_SUB;
        state_next = S_W2_ADD;
      end
      S_W2_ADD: begin
        op         = mfek_pkg::OP_W2_ADD;
        state_next = S_W2_PAR;
      end
      S_ACC: begin
        op = mfek_pkg::OP_ACC;
        if (status.bott_zero) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_BFS_INIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/max_flow_edmonds_karp_core.sv =====
// edmonds-karp max flow core: clear (also at reset, busy high) writes all 4^NW residual
// entries (4096 at defaults); edge add updates both ways (one for a self-loop, none
// if out of range); run: each search scans all n vertices per dequeued vertex, then a
// bottleneck walk (par, fwd, cmp per hop) and an update walk (par, fwd, sub, add) on the
// single residual ram port. result beat: busy low, in the cycle after the last step
// depends on mfek_pkg, mfek_ctrl, mfek_dp
`default_nettype none
module max_flow_edmonds_karp_core #(
  parameter int MAX_NODES = 64,
  parameter int CAP_WIDTH = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire mfek_pkg::item_t                 item,
  output logic                                 busy,
  output logic                                 done,
  output mfek_pkg::result_t                    result,
  input  wire logic                            cfg_write,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [mfek_pkg::CFG_DATA_W-1:0] cfg_data
);

  mfek_pkg::dp_op_t     op;
  mfek_pkg::dp_status_t status;

  mfek_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (item.command),
    .status  (status),
    .op      (op),
    .busy    (busy),
    .done    (done)
  );

  mfek_dp #(.MAX_NODES(MAX_NODES), .CAP_WIDTH(CAP_WIDTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .result    (result)
  );

endmodule
`default_nettype wire

// ===== rtl/core/mfek_chk.sv =====
// port checker for the max flow core, attached by bind
// depends on mfek_pkg and max_flow_edmonds_karp_core
`default_nettype none
module mfek_chk (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire mfek_pkg::item_t   item,
  input wire logic              busy,
  input wire logic              done,
  input wire mfek_pkg::result_t result
);

  // a result beat always ends a busy stretch
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result beat without preceding work");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    done && result.flow_saturated |-> result.flow_total == 32'hFFFF_FFFF)
    else $error("saturation flag with unsaturated total");

  // only a run beat yields a result
  a_no_result_non_run: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.command != mfek_pkg::CMD_RUN) |=> !done)
    else $error("result beat after a non-run command");

  a_run_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.command == mfek_pkg::CMD_RUN) |=> busy)
    else $error("run beat did not start work");

endmodule

bind max_flow_edmonds_karp_core mfek_chk u_chk (.*);
`default_nettype wire
